@@ src/drpd_pkg.sv @@
// Shared types and constants for the delta run pixel decoder.
package drpd_pkg;

    localparam int CHANNELS    = 4;
    localparam int COLOR_WIDTH = 16;
    localparam int DELTA_WIDTH = 7;
    localparam int DELTA_LSB   = 4;
    localparam int RUN_WIDTH   = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_WIDTH   = 1;
    localparam int QCNT_WIDTH  = 2;

    // Chunk position within a cell; the third chunk always closes the cell.
    localparam logic [1:0] POS_FIRST = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LAST = 2'd2;

    typedef logic [COLOR_WIDTH-1:0] color_t;
    typedef logic [CHANNELS-1:0][COLOR_WIDTH-1:0] rgba_t;
    typedef logic [RUN_WIDTH-1:0] run_t;

    // One run handed from the front end to the pixel emitter.
    typedef struct packed {
        rgba_t color;
        run_t  emit;
        logic  image_done;
    } job_t;

    // Queue head as seen by the emitter.
    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

endpackage

@@ src/drpd_chunk_if.sv @@
// Chunk word channel: valid/ready handshake with a 32-bit payload.
interface drpd_chunk_if;
    logic        valid;
    logic        ready;
    logic [31:0] chunk_word;

    modport source (output valid, output chunk_word, input ready);
    modport sink (input valid, input chunk_word, output ready);
endinterface

@@ src/drpd_pixel_if.sv @@
// Pixel channel: valid/ready handshake with the decoded RGBA pixel and flags.
interface drpd_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_value;
    logic [15:0] green_value;
    logic [15:0] blue_value;
    logic [15:0] opacity_value;
    logic        run_last;
    logic        image_end;

    modport source (output valid, output red_value, output green_value, output blue_value,
                    output opacity_value, output run_last, output image_end, input ready);
    modport sink (input valid, input red_value, input green_value, input blue_value,
                  input opacity_value, input run_last, input image_end, output ready);
endinterface

@@ src/drpd_front.sv @@
// Front end: collects chunk deltas, updates the color and clips runs to the image.
module drpd_front #(
    parameter int CELL_COUNT_WIDTH = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    drpd_chunk_if.sink                  chunk,
    input  logic                        cfg_we,
    input  logic [CELL_COUNT_WIDTH-1:0] cfg_wdata,
    input  logic                        full,
    output logic                        push,
    output drpd_pkg::job_t              job
);

    localparam int W = CELL_COUNT_WIDTH;

    drpd_pkg::rgba_t color_reg;
    drpd_pkg::rgba_t delta_sum_reg;
    logic [1:0]      pos_reg;
    logic [W-1:0]    emitted_reg;
    logic [W-1:0]    total_reg;

    drpd_pkg::rgba_t sum_next;
    drpd_pkg::rgba_t color_next;
    drpd_pkg::run_t  count;
    drpd_pkg::run_t  emit;
    logic [W-1:0]    remaining;
    logic [W-1:0]    emitted_next;
    logic            accept;
    logic            hold;
    logic            done;

    always_comb
    begin
        logic [drpd_pkg::DELTA_WIDTH-1:0] d;
        drpd_pkg::color_t                 dext;
        drpd_pkg::color_t                 shifted;
        for (int i = 0; i < drpd_pkg::CHANNELS; i++)
        begin
            d = chunk.chunk_word[drpd_pkg::DELTA_LSB + drpd_pkg::DELTA_WIDTH*i +:
                                 drpd_pkg::DELTA_WIDTH];
            dext = {{(drpd_pkg::COLOR_WIDTH-drpd_pkg::DELTA_WIDTH){d[drpd_pkg::DELTA_WIDTH-1]}},
                    d};
            case (pos_reg)
                drpd_pkg::POS_FIRST:  shifted = dext;
                drpd_pkg::POS_SECOND: shifted = {dext[8:0], 7'b0};
                default:              shifted = {dext[1:0], 14'b0};
            endcase
            sum_next[i]   = delta_sum_reg[i] + shifted;
            color_next[i] = color_reg[i] + sum_next[i];
        end
    end

    assign count      = chunk.chunk_word[drpd_pkg::RUN_WIDTH-1:0];
    assign remaining  = (total_reg > emitted_reg) ? (total_reg - emitted_reg) : '0;
    assign emit       = ({{(W-drpd_pkg::RUN_WIDTH){1'b0}}, count} > remaining)
                        ? remaining[drpd_pkg::RUN_WIDTH-1:0] : count;
    assign emitted_next = emitted_reg + {{(W-drpd_pkg::RUN_WIDTH){1'b0}}, emit};
    assign done       = (emit != '0) && (emitted_next == total_reg);
    assign hold       = (count == '0) && (pos_reg != drpd_pkg::POS_LAST);

    assign chunk.ready = !full;
    assign accept      = chunk.valid && !full;
    assign push        = accept && !hold && (emit != '0);

    assign job.color      = color_next;
    assign job.emit       = emit;
    assign job.image_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= '0;
            delta_sum_reg <= '0;
            pos_reg       <= drpd_pkg::POS_FIRST;
            emitted_reg   <= '0;
            total_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (hold)
                begin
                    delta_sum_reg <= sum_next;
                    pos_reg       <= pos_reg + 2'd1;
                end
                else
                begin
                    delta_sum_reg <= '0;
                    pos_reg       <= drpd_pkg::POS_FIRST;
                    if (done)
                    begin
                        // image complete: start the next one from black
                        color_reg   <= '0;
                        emitted_reg <= '0;
                    end
                    else
                    begin
                        color_reg   <= color_next;
                        emitted_reg <= emitted_next;
                    end
                end
            end
        end
    end

endmodule

@@ src/drpd_queue.sv @@
// Short run queue between the front end and the pixel emitter.
module drpd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  drpd_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output drpd_pkg::head_t head
);

    drpd_pkg::job_t                     mem [drpd_pkg::QUEUE_DEPTH];
    logic [drpd_pkg::PTR_WIDTH-1:0]     wr_ptr_reg;
    logic [drpd_pkg::PTR_WIDTH-1:0]     rd_ptr_reg;
    logic [drpd_pkg::QCNT_WIDTH-1:0]    count_reg;
    logic                               do_pop;

    assign full       = (count_reg == drpd_pkg::QCNT_WIDTH'(drpd_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/drpd_back.sv @@
// Pixel emitter: repeats the head run's color into the output register.
module drpd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  drpd_pkg::head_t head,
    output logic            pop,
    drpd_pixel_if.source    pixel
);

    drpd_pkg::run_t  idx_reg;
    logic            valid_reg;
    drpd_pkg::rgba_t color_reg;
    logic            last_reg;
    logic            end_reg;

    drpd_pkg::run_t  idx_inc;
    logic            advance;
    logic            last;

    assign advance = !valid_reg || pixel.ready;
    assign idx_inc = idx_reg + 1'b1;
    assign last    = (idx_inc == head.job.emit);
    assign pop     = advance && head.valid && last;

    assign pixel.valid         = valid_reg;
    assign pixel.red_value     = color_reg[0];
    assign pixel.green_value   = color_reg[1];
    assign pixel.blue_value    = color_reg[2];
    assign pixel.opacity_value = color_reg[3];
    assign pixel.run_last      = last_reg;
    assign pixel.image_end     = end_reg;

    always_ff @(posedge clk)
    begin
        if (advance && head.valid)
        begin
            color_reg <= head.job.color;
            last_reg  <= last;
            end_reg   <= last && head.job.image_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= head.valid;
            if (head.valid)
            begin
                idx_reg <= last ? '0 : idx_inc;
            end
        end
    end

endmodule

@@ src/delta_run_pixel_decoder.sv @@
// Delta run pixel decoder: chunk words in, 16-bit RGBA pixels out.
// First pixel of a run: written into the run queue, then into the output register,
//   where it waits while the receiver is not ready.
// Throughput: one chunk per cycle while runs are a single pixel and the queue is not
//   full; a run of n pixels leaves one pixel per cycle while the receiver is ready.
// Reset (rst_n, async, active low) clears color, deltas, pixel count, cell total
//   and the run queue; no clearing pass.
module delta_run_pixel_decoder #(
    parameter int CELL_COUNT_WIDTH = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    drpd_chunk_if.sink                  chunk,
    drpd_pixel_if.source                pixel,
    input  logic                        cfg_we,
    input  logic [CELL_COUNT_WIDTH-1:0] cfg_wdata
);

    // Front end to queue: one job per cell that emits at least one pixel.
    logic            push;
    logic            full;
    logic            pop;
    drpd_pkg::job_t  job;
    drpd_pkg::head_t head;

    // Front end: sum the deltas of up to three chunks at weights 1, 128 and
    // 16384, apply them to the kept color, clip the run to the pixels still
    // missing in the image, and reset color and count at the image end.
    drpd_front #(
        .CELL_COUNT_WIDTH (CELL_COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chunk     (chunk),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .full      (full),
        .push      (push),
        .job       (job)
    );

    // Queue: decouple chunk intake from pixel emission so a stalled output
    // does not stop continuation chunks until the queue fills.
    drpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .full     (full),
        .head     (head)
    );

    // Back end: emit the head color once per pixel, mark the last pixel of
    // the run, and flag the image end on it when the run completed the image.
    drpd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .pixel (pixel)
    );

    // Never push a run into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("run pushed into full queue");

    // Image end only ever falls on the last pixel of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.image_end) |-> pixel.run_last)
        else $error("image end off run boundary");

    // Every queued run has at least one pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (job.emit != '0))
        else $error("empty run queued");

endmodule

@@ bench/delta_run_pixel_decoder_tb.sv @@
// Self-checking bench for the delta run pixel decoder: directed chunks, then random cells.
`timescale 1ns / 100ps

module delta_run_pixel_decoder_tb;

    localparam int CELL_COUNT_WIDTH = 40;
    // Cycles to hold after the last pixel so a chunk that emits nothing has settled.
    localparam int SETTLE_CYCLES = 4;
    // Cycles without any accepted word before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef logic [CELL_COUNT_WIDTH-1:0] count_t;

    // One decoded pixel as it leaves the block.
    typedef struct packed {
        drpd_pkg::color_t red;
        drpd_pkg::color_t green;
        drpd_pkg::color_t blue;
        drpd_pkg::color_t opacity;
        logic             run_last;
        logic             image_end;
    } pixel_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    count_t cfg_wdata;

    drpd_chunk_if chunk_ch ();
    drpd_pixel_if pixel_ch ();

    delta_run_pixel_decoder #(
        .CELL_COUNT_WIDTH(CELL_COUNT_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .chunk    (chunk_ch),
        .pixel    (pixel_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Decoder state mirrored on the bench side.
    drpd_pkg::color_t color_now [drpd_pkg::CHANNELS];
    drpd_pkg::color_t delta_acc [drpd_pkg::CHANNELS];
    logic [1:0]       cell_pos;
    count_t           pixels_done;
    count_t           image_size;

    // Pixels predicted but not yet seen at the output, oldest first.
    pixel_t     pixel_q [$];

    // Idle and stall odds, in percent, for the phase under way.
    int send_idle_pct;
    int recv_stall_pct;

    int error_count;
    int chunk_count;
    int pixel_count;
    int image_end_count;
    int setting_count;
    int hang_cycles;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic string pixel_text(input pixel_t p);
        return $sformatf("rgba=%04h/%04h/%04h/%04h last=%0b end=%0b",
                         p.red, p.green, p.blue, p.opacity, p.run_last, p.image_end);
    endfunction

    // Count a failure; spell out only the first few.
    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Pack a chunk word: run count in the low nibble, four 7-bit deltas above.
    function automatic logic [31:0] make_chunk(input int count, input int red,
                                               input int green, input int blue,
                                               input int opacity);
        logic [31:0] word;
        word = {opacity[6:0], blue[6:0], green[6:0], red[6:0], count[3:0]};
        return word;
    endfunction

    // Random deltas around a chosen run count.
    function automatic logic [31:0] random_chunk(input int count);
        logic [31:0] word;
        word = $urandom();
        word[drpd_pkg::RUN_WIDTH-1:0] = count[drpd_pkg::RUN_WIDTH-1:0];
        return word;
    endfunction

    // Advance the mirrored state by one accepted chunk word and queue the pixels it yields.
    task automatic predict_chunk(input logic [31:0] word);
        drpd_pkg::run_t   count;
        drpd_pkg::color_t step;
        count_t           left;
        int               lsb;
        int               n_emit;
        pixel_t           entry;

        count = word[drpd_pkg::RUN_WIDTH-1:0];
        // Collect deltas at weight 1, 128 or 16384 by position in the cell.
        for (int ch = 0; ch < drpd_pkg::CHANNELS; ch++) begin
            lsb  = drpd_pkg::DELTA_LSB + drpd_pkg::DELTA_WIDTH * ch;
            step = {{(drpd_pkg::COLOR_WIDTH - drpd_pkg::DELTA_WIDTH)
                     {word[lsb + drpd_pkg::DELTA_WIDTH - 1]}},
                    word[lsb +: drpd_pkg::DELTA_WIDTH]};
            delta_acc[ch] = delta_acc[ch]
                            + drpd_pkg::color_t'(step << (drpd_pkg::DELTA_WIDTH * cell_pos));
        end

        // Continuation word: hold the deltas, nothing comes out.
        if (count == '0 && cell_pos != drpd_pkg::POS_LAST) begin
            cell_pos = cell_pos + 2'd1;
            return;
        end

        // Cell closes: fold the deltas into the color.
        for (int ch = 0; ch < drpd_pkg::CHANNELS; ch++) begin
            color_now[ch] = color_now[ch] + delta_acc[ch];
            delta_acc[ch] = '0;
        end
        cell_pos = drpd_pkg::POS_FIRST;

        // Clip the run to what the image still lacks; a full image emits nothing.
        left   = (image_size > pixels_done) ? image_size - pixels_done : '0;
        n_emit = (count_t'(count) > left) ? int'(left) : int'(count);

        for (int k = 0; k < n_emit; k++) begin
            pixels_done     = pixels_done + 1'b1;
            entry.red       = color_now[0];
            entry.green     = color_now[1];
            entry.blue      = color_now[2];
            entry.opacity   = color_now[3];
            entry.run_last  = (k == n_emit - 1);
            entry.image_end = (pixels_done == image_size);
            pixel_q.push_back(entry);
        end

        // Image complete: start the next one from black at pixel zero.
        if (n_emit > 0 && pixels_done == image_size) begin
            for (int ch = 0; ch < drpd_pkg::CHANNELS; ch++)
                color_now[ch] = '0;
            pixels_done = '0;
        end
    endtask

    // Offer one chunk word, maybe after a random gap, and hold it until accepted.
    // Valid stays high on return so back-to-back words need no second assignment.
    task automatic send_chunk(input logic [31:0] word);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            chunk_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        chunk_ch.valid      <= 1'b1;
        chunk_ch.chunk_word <= word;
        do
            @(posedge clk);
        while (!chunk_ch.ready);
        predict_chunk(word);
        chunk_count++;
    endtask

    // Drop valid and wait until every predicted pixel is out, then let the block settle.
    task automatic drain_pipeline();
        chunk_ch.valid <= 1'b0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the cell total; call only with the block drained.
    task automatic write_cell_total(input count_t value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        image_size = value;
        setting_count++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Single-word cells at the field extremes: zero, maximal runs, the delta limits.
    task automatic test_field_extremes();
        write_cell_total('1);
        send_chunk(make_chunk(1, 0, 0, 0, 0));
        send_chunk(32'hFFFF_FFFF);
        send_chunk(make_chunk(15, 63, 63, 63, 63));
        send_chunk(make_chunk(1, -64, -64, -64, -64));
        send_chunk(32'hAAAA_AAAA);
        send_chunk(32'h5555_5555);
        drain_pipeline();
    endtask

    // Two- and three-word cells, including a third word with a zero count.
    task automatic test_continuation_cells();
        send_chunk(32'h0000_0000);
        send_chunk(make_chunk(3, 1, -1, 63, -64));

        send_chunk(make_chunk(0, -64, 63, 1, -1));
        send_chunk(make_chunk(0, 63, -64, -1, 1));
        send_chunk(make_chunk(2, -64, -64, 63, 63));

        // Third word with count zero closes the cell silently; the next run shows the color.
        send_chunk(make_chunk(0, 7, 7, 7, 7));
        send_chunk(make_chunk(0, -7, 5, -3, 2));
        send_chunk(make_chunk(0, 1, 2, 3, 4));
        send_chunk(make_chunk(1, 0, 0, 0, 0));
        drain_pipeline();
    endtask

    // Runs longer than the pixels left: clip and flag the image end on the last one.
    task automatic test_run_clipping();
        write_cell_total(pixels_done + 5);
        send_chunk(make_chunk(3, 2, 4, 6, 8));
        send_chunk(make_chunk(4, -2, -4, -6, -8));
        drain_pipeline();
        write_cell_total(1);
        send_chunk(make_chunk(15, 3, -3, 5, -5));
        drain_pipeline();
    endtask

    // Empty image, and a total lowered below what was already emitted.
    task automatic test_image_full();
        write_cell_total('0);
        send_chunk(make_chunk(7, 1, 1, 1, 1));
        drain_pipeline();
        write_cell_total(10);
        send_chunk(make_chunk(6, 9, -9, 17, -17));
        drain_pipeline();
        write_cell_total(3);
        send_chunk(make_chunk(4, -30, 30, -1, 1));
        drain_pipeline();
    endtask

    // Mostly well-formed cells with random deltas, some raw noise words, and the
    // odd full drain mid-stream.
    task automatic test_random_cells(input int idle_pct, input int stall_pct,
                                     input int n_words, input int size_lo, input int size_hi);
        int sent;
        int n_cont;
        int count;

        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_cell_total(count_t'($urandom_range(size_hi, size_lo)));
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 80) begin
                n_cont = $urandom_range(2);
                repeat (n_cont) send_chunk(random_chunk(0));
                if ($urandom_range(9) < 6)
                    count = $urandom_range(3, 1);
                else
                    count = $urandom_range(15, 1);
                if (n_cont == 2 && $urandom_range(7) == 0)
                    count = 0;
                send_chunk(random_chunk(count));
                sent += n_cont + 1;
            end else begin
                send_chunk($urandom());
                sent++;
            end
            if ($urandom_range(19) == 0)
                drain_pipeline();
        end
        drain_pipeline();
    endtask

    // Toggle receiver readiness at the phase's stall odds.
    always @(posedge clk)
        pixel_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Check each accepted pixel against the oldest prediction.
    always @(posedge clk) begin : pixel_check
        pixel_t seen;
        pixel_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready) begin
            seen.red       = pixel_ch.red_value;
            seen.green     = pixel_ch.green_value;
            seen.blue      = pixel_ch.blue_value;
            seen.opacity   = pixel_ch.opacity_value;
            seen.run_last  = pixel_ch.run_last;
            seen.image_end = pixel_ch.image_end;
            pixel_count++;
            if (seen.image_end)
                image_end_count++;
            if (pixel_q.size() == 0) begin
                note_failure({"unexpected pixel ", pixel_text(seen)});
            end else begin
                want = pixel_q.pop_front();
                if (seen !== want)
                    note_failure({"expected ", pixel_text(want), ", got ", pixel_text(seen)});
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk) begin
        if ((chunk_ch.valid && chunk_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT) begin
            $display("[%0t] no word accepted for %0d cycles, %0d pixels pending",
                     $realtime, HANG_LIMIT, pixel_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int ch = 0; ch < drpd_pkg::CHANNELS; ch++) begin
            color_now[ch] = '0;
            delta_acc[ch] = '0;
        end
        cell_pos        = drpd_pkg::POS_FIRST;
        pixels_done     = '0;
        image_size      = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        chunk_count     = 0;
        setting_count   = 0;

        // Drive reset, configuration and chunk inputs from time zero, then hold reset low.
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        chunk_ch.valid      <= 1'b0;
        chunk_ch.chunk_word <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_field_extremes();
        test_continuation_cells();
        test_run_clipping();
        test_image_full();

        // Random phases: free flowing, sparse sender, stalling receiver, both mildly.
        test_random_cells(0, 0, 40, 8, 60);
        test_random_cells(78, 0, 35, 8, 40);
        test_random_cells(0, 78, 35, 8, 40);
        test_random_cells(22, 22, 40, 20, 200);

        drain_pipeline();

        $display("covered: %0d chunk words, %0d cell total settings incl. zero and all ones",
                 chunk_count, setting_count);
        $display("checked: %0d pixels, %0d image ends, %0d failures",
                 pixel_count, image_end_count, error_count);
        if (error_count == 0 && pixel_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (pixel_q.size() != 0)
                $display("%0d predicted pixels never arrived", pixel_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/drpd_pkg.sv
src/drpd_chunk_if.sv
src/drpd_pixel_if.sv
src/drpd_front.sv
src/drpd_queue.sv
src/drpd_back.sv
src/delta_run_pixel_decoder.sv
bench/delta_run_pixel_decoder_tb.sv
